### src/tsau_pkg.sv
package tsau_pkg;

   // time constants
   localparam logic [31:0] NS_PER_S  = 32'd1_000_000_000;
   localparam logic [19:0] NS_PER_MS = 20'd1_000_000;
   localparam logic [9:0]  MS_PER_S  = 10'd1000;

   // difference order codes
   localparam logic [1:0] ORDER_EQUAL     = 2'd0;
   localparam logic [1:0] ORDER_A_SMALLER = 2'd1;
   localparam logic [1:0] ORDER_A_LARGER  = 2'd2;

   typedef enum logic [1:0] {
      ACT_NORMALIZE,
      ACT_ADD,
      ACT_ADD_MSEC,
      ACT_DIFF
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [63:0] a_sec;
      logic [31:0] a_nsec;
      logic [63:0] b_sec;
      logic [31:0] b_nsec;
      logic [63:0] msec_amount;
      logic        ignore_overflow;
   } req_type;

   typedef struct packed {
      logic [63:0] res_sec;
      logic [31:0] res_nsec;
      logic        written;
      logic        overflow;
      logic [1:0]  order;
   } rsp_type;

   // operands after the first value is folded and the second is chosen
   typedef struct packed {
      logic [63:0] a_sec;
      logic        a_carry;
      logic [29:0] a_nsec;
      logic [63:0] b_sec;
      logic [31:0] b_nsec;
   } prep_type;

   typedef struct packed {
      logic [63:0] sec;
      logic [29:0] nsec;
      logic        overflow;
   } time_res_type;

   typedef struct packed {
      logic [2:0]  whole;
      logic [29:0] frac;
   } nsec_split_type;

   // split a nanosecond count into whole seconds (at most four) and the rest
   function automatic nsec_split_type nsec_split(input logic [31:0] nsec);
      nsec_split_type split;
      split.whole = '0;
      split.frac  = nsec[29:0];
      for (int k = 1; k <= 4; k++) begin
         if (nsec >= 32'(k) * NS_PER_S) begin
            split.whole = 3'(k);
            split.frac  = 30'(nsec - 32'(k) * NS_PER_S);
         end
      end
      return split;
   endfunction

endpackage

### src/tsau_stream_if.sv
interface tsau_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/timespec_arith_unit.sv
// Seconds-plus-nanoseconds arithmetic unit.
// req_if carries one operation per transfer: action selects normalize, add,
// add milliseconds or absolute difference on (a_sec, a_nsec) and
// (b_sec, b_nsec) or msec_amount. rsp_if returns exactly one result per
// request, in request order: res_sec, res_nsec (below one second), written,
// overflow and, for a difference, the operand order.
// From the request transfer to rsp_if.valid there are four stages of a
// radix-16 divide-by-1000 on msec_amount, one operand prep stage, three
// stages of the add or difference datapath and the output register. One
// request is taken every cycle unless rsp_if.ready stalls the full pipeline;
// the divider and 64-bit adders are all pipelined; no loop limits throughput.
// Each stage carries its own valid bit and moves on when the next stage is
// empty or moving, so bubbles collapse. When the receiver holds rsp_if.ready
// low, the pipeline fills and req_if.ready drops once all nine stages hold
// an item; nothing is dropped or repeated.
// Reset (synchronous, active high) clears every valid bit; items in flight
// are discarded. No clearing pass is needed, the unit holds no state.
module timespec_arith_unit
   import tsau_pkg::*;
(
   input logic           clock,
   input logic           reset,
   tsau_stream_if.sink   req_if,
   tsau_stream_if.source rsp_if
);

   localparam int DivStages  = 4;
   localparam int PathStages = 3;
   localparam int Stages     = DivStages + PathStages + 2;

   typedef struct packed {
      action_type action;
      logic       ignore_overflow;
   } ctrl_type;

   logic [Stages-1:0] valid_ff, valid_in;
   logic [Stages:0]   stage_en;

   req_type      pay_ff [DivStages];
   ctrl_type     ctrl_ff [PathStages + 1];
   prep_type     prep_ff, prep_in;
   rsp_type      rsp_ff, rsp_in;

   logic [63:0]  quotient;
   logic [9:0]   remainder;
   time_res_type add_res;
   time_res_type norm_res;
   time_res_type diff_res;
   logic [1:0]   diff_order;

   // per-stage advance: a stage loads when empty or when the next one moves
   always_comb begin
      stage_en[Stages] = rsp_if.ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k + 1];
      end
   end

   always_comb begin
      valid_in[0] = stage_en[0] ? req_if.valid : valid_ff[0];
      for (int k = 1; k < Stages; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k - 1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_if.ready   = stage_en[0];
   assign rsp_if.valid   = valid_ff[Stages - 1];
   assign rsp_if.payload = rsp_ff;

   // request fields ride alongside the divider
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pay_ff[0] <= req_if.payload;
      end
      for (int k = 1; k < DivStages; k++) begin
         if (stage_en[k]) begin
            pay_ff[k] <= pay_ff[k - 1];
         end
      end
   end

   tsau_div1000 u_div (
      .clock     (clock),
      .stage_en  (stage_en[DivStages-1:0]),
      .dividend  (req_if.payload.msec_amount),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // operand prep: fold the first value, pick the second operand
   always_comb begin
      nsec_split_type a_split;
      logic [64:0]    a_sum;
      logic [29:0]    msec_ns;
      a_split = nsec_split(pay_ff[DivStages - 1].a_nsec);
      a_sum   = {1'b0, pay_ff[DivStages - 1].a_sec} + 65'(a_split.whole);
      msec_ns = 30'(remainder) * 30'(NS_PER_MS);
      prep_in.a_sec   = a_sum[63:0];
      prep_in.a_carry = a_sum[64];
      prep_in.a_nsec  = a_split.frac;
      if (pay_ff[DivStages - 1].action == ACT_ADD_MSEC) begin
         prep_in.b_sec  = quotient;
         prep_in.b_nsec = 32'(msec_ns);
      end else begin
         prep_in.b_sec  = pay_ff[DivStages - 1].b_sec;
         prep_in.b_nsec = pay_ff[DivStages - 1].b_nsec;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[DivStages]) begin
         prep_ff    <= prep_in;
         ctrl_ff[0] <= '{action: pay_ff[DivStages - 1].action,
                         ignore_overflow: pay_ff[DivStages - 1].ignore_overflow};
      end
      for (int k = 1; k <= PathStages; k++) begin
         if (stage_en[DivStages + k]) begin
            ctrl_ff[k] <= ctrl_ff[k - 1];
         end
      end
   end

   tsau_sum_path u_sum (
      .clock    (clock),
      .stage_en (stage_en[DivStages + 1 +: PathStages]),
      .prep     (prep_ff),
      .add_res  (add_res),
      .norm_res (norm_res)
   );

   tsau_diff_path u_diff (
      .clock      (clock),
      .stage_en   (stage_en[DivStages + 1 +: PathStages]),
      .prep       (prep_ff),
      .diff_res   (diff_res),
      .diff_order (diff_order)
   );

   // result select and overflow write-suppression
   always_comb begin
      time_res_type sel;
      sel = norm_res;
      rsp_in.order = ORDER_EQUAL;
      case (ctrl_ff[PathStages].action)
         ACT_NORMALIZE: begin
            sel = norm_res;
         end
         ACT_ADD, ACT_ADD_MSEC: begin
            sel = add_res;
         end
         ACT_DIFF: begin
            sel = diff_res;
            rsp_in.order = diff_order;
         end
         default: begin
            sel = norm_res;
         end
      endcase
      rsp_in.overflow = sel.overflow;
      rsp_in.written  = !sel.overflow || ctrl_ff[PathStages].ignore_overflow;
      rsp_in.res_sec  = rsp_in.written ? sel.sec : '0;
      rsp_in.res_nsec = rsp_in.written ? 32'(sel.nsec) : '0;
   end

   always_ff @(posedge clock) begin
      if (stage_en[Stages - 1]) begin
         rsp_ff <= rsp_in;
      end
   end

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("result valid after reset");

   // results are always normalized
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.payload.res_nsec < NS_PER_S)
      else $error("result nanoseconds not normalized");

   // a suppressed write comes only from an overflow and carries a zero result
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.payload.written |->
         rsp_if.payload.overflow && rsp_if.payload.res_sec == '0 &&
         rsp_if.payload.res_nsec == '0)
      else $error("unwritten result without overflow or with data");

   // a full pipeline facing a stalled receiver takes no new request
   assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !rsp_if.ready |-> !req_if.ready)
      else $error("request taken while pipeline full and stalled");

endmodule

### src/tsau_div1000.sv
module tsau_div1000
   import tsau_pkg::*;
(
   input  logic        clock,
   input  logic [3:0]  stage_en,
   input  logic [63:0] dividend,
   output logic [63:0] quotient,
   output logic [9:0]  remainder
);

   localparam int Stages         = 4;
   localparam int DigitsPerStage = 64 / (4 * Stages);

   typedef struct packed {
      logic [63:0] num;
      logic [63:0] quo;
      logic [9:0]  rem;
   } div_stage_type;

   div_stage_type stage_ff [Stages];
   div_stage_type first_stage;

   // one radix-16 long division step: returns quotient digit and new remainder
   function automatic logic [13:0] div_digit(input logic [9:0] rem, input logic [3:0] digit);
      logic [13:0] part;
      logic [3:0]  qd;
      logic [9:0]  r;
      part = {rem, digit};
      qd   = '0;
      r    = part[9:0];
      for (int k = 1; k < 16; k++) begin
         if (part >= 14'(k) * 14'(MS_PER_S)) begin
            qd = 4'(k);
            r  = 10'(part - 14'(k) * 14'(MS_PER_S));
         end
      end
      return {qd, r};
   endfunction

   assign first_stage = '{num: dividend, quo: '0, rem: '0};

   // each stage retires sixteen dividend bits, msb first
   for (genvar g = 0; g < Stages; g++) begin : g_stage
      div_stage_type prev;
      div_stage_type stage_in;

      if (g == 0) begin : g_first
         assign prev = first_stage;
      end else begin : g_next
         assign prev = stage_ff[g - 1];
      end

      always_comb begin
         logic [13:0] step;
         stage_in = prev;
         for (int d = 0; d < DigitsPerStage; d++) begin
            step = div_digit(stage_in.rem, prev.num[63 - 4 * (g * DigitsPerStage + d) -: 4]);
            stage_in.quo[63 - 4 * (g * DigitsPerStage + d) -: 4] = step[13:10];
            stage_in.rem = step[9:0];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[g]) begin
            stage_ff[g] <= stage_in;
         end
      end
   end

   assign quotient  = stage_ff[Stages - 1].quo;
   assign remainder = stage_ff[Stages - 1].rem;

endmodule

### src/tsau_sum_path.sv
module tsau_sum_path
   import tsau_pkg::*;
(
   input  logic         clock,
   input  logic [2:0]   stage_en,
   input  prep_type     prep,
   output time_res_type add_res,
   output time_res_type norm_res
);

   typedef struct packed {
      time_res_type norm;
      logic [63:0]  sec;
      logic         ovf;
      logic [2:0]   b_whole;
      logic [29:0]  b_frac;
      logic [30:0]  nsec;
   } sum_stage_type;

   sum_stage_type st1_ff, st1_in;
   sum_stage_type st2_ff, st2_in;
   sum_stage_type st3_ff, st3_in;

   // add the second seconds, split the second nanoseconds
   always_comb begin
      logic [64:0]    sum;
      nsec_split_type split;
      sum   = {1'b0, prep.a_sec} + {1'b0, prep.b_sec};
      split = nsec_split(prep.b_nsec);
      st1_in.norm    = '{sec: prep.a_sec, nsec: prep.a_nsec, overflow: prep.a_carry};
      st1_in.sec     = sum[63:0];
      st1_in.ovf     = prep.a_carry | sum[64];
      st1_in.b_whole = split.whole;
      st1_in.b_frac  = split.frac;
      st1_in.nsec    = 31'(prep.a_nsec);
   end

   // add whole seconds of the second nanoseconds, sum the nanoseconds
   always_comb begin
      logic [64:0] sum;
      sum    = {1'b0, st1_ff.sec} + 65'(st1_ff.b_whole);
      st2_in = st1_ff;
      st2_in.sec  = sum[63:0];
      st2_in.ovf  = st1_ff.ovf | sum[64];
      st2_in.nsec = st1_ff.nsec + 31'(st1_ff.b_frac);
   end

   // final fold of the nanosecond sum
   always_comb begin
      logic        fold;
      logic [64:0] sum;
      fold   = st2_ff.nsec >= 31'(NS_PER_S);
      sum    = {1'b0, st2_ff.sec} + 65'(fold);
      st3_in = st2_ff;
      st3_in.sec  = sum[63:0];
      st3_in.ovf  = st2_ff.ovf | sum[64];
      st3_in.nsec = fold ? (st2_ff.nsec - 31'(NS_PER_S)) : st2_ff.nsec;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         st1_ff <= st1_in;
      end
      if (stage_en[1]) begin
         st2_ff <= st2_in;
      end
      if (stage_en[2]) begin
         st3_ff <= st3_in;
      end
   end

   assign add_res  = '{sec: st3_ff.sec, nsec: st3_ff.nsec[29:0], overflow: st3_ff.ovf};
   assign norm_res = st3_ff.norm;

endmodule

### src/tsau_diff_path.sv
module tsau_diff_path
   import tsau_pkg::*;
(
   input  logic         clock,
   input  logic [2:0]   stage_en,
   input  prep_type     prep,
   output time_res_type diff_res,
   output logic [1:0]   diff_order
);

   typedef struct packed {
      logic [64:0] a_sec;
      logic [29:0] a_nsec;
      logic [64:0] b_sec;
      logic [29:0] b_nsec;
      logic        borrow;
      logic [1:0]  order;
   } diff_stage_type;

   diff_stage_type st1_ff, st1_in;
   diff_stage_type st2_ff, st2_in;
   diff_stage_type st3_ff, st3_in;
   logic [64:0]    diff_sec;

   // exact normalization of both operands into 65-bit seconds
   always_comb begin
      nsec_split_type split;
      split = nsec_split(prep.b_nsec);
      st1_in.a_sec  = {prep.a_carry, prep.a_sec};
      st1_in.a_nsec = prep.a_nsec;
      st1_in.b_sec  = {1'b0, prep.b_sec} + 65'(split.whole);
      st1_in.b_nsec = split.frac;
      st1_in.borrow = 1'b0;
      st1_in.order  = ORDER_EQUAL;
   end

   // order the operands: larger in the a fields, smaller in the b fields
   always_comb begin
      logic a_gt;
      logic eq;
      a_gt = {st1_ff.a_sec, st1_ff.a_nsec} > {st1_ff.b_sec, st1_ff.b_nsec};
      eq   = {st1_ff.a_sec, st1_ff.a_nsec} == {st1_ff.b_sec, st1_ff.b_nsec};
      st2_in = st1_ff;
      if (a_gt) begin
         st2_in.order = ORDER_A_LARGER;
      end else begin
         st2_in.a_sec  = st1_ff.b_sec;
         st2_in.a_nsec = st1_ff.b_nsec;
         st2_in.b_sec  = st1_ff.a_sec;
         st2_in.b_nsec = st1_ff.a_nsec;
         st2_in.order  = eq ? ORDER_EQUAL : ORDER_A_SMALLER;
      end
   end

   // subtract seconds and nanoseconds, keep the nanosecond borrow
   always_comb begin
      st3_in = st2_ff;
      st3_in.a_sec  = st2_ff.a_sec - st2_ff.b_sec;
      st3_in.borrow = st2_ff.a_nsec < st2_ff.b_nsec;
      if (st3_in.borrow) begin
         st3_in.a_nsec = 30'(31'(st2_ff.a_nsec) + 31'(NS_PER_S) - 31'(st2_ff.b_nsec));
      end else begin
         st3_in.a_nsec = st2_ff.a_nsec - st2_ff.b_nsec;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         st1_ff <= st1_in;
      end
      if (stage_en[1]) begin
         st2_ff <= st2_in;
      end
      if (stage_en[2]) begin
         st3_ff <= st3_in;
      end
   end

   // apply the borrow; a seconds difference beyond 64 bits is an overflow
   assign diff_sec   = st3_ff.a_sec - 65'(st3_ff.borrow);
   assign diff_res   = '{sec: diff_sec[63:0], nsec: st3_ff.a_nsec, overflow: diff_sec[64]};
   assign diff_order = st3_ff.order;

endmodule
